/* rtl/core/obtl_pkg.sv */
// ----------------------------------------------------------------------------
// obtl_pkg
// Shared types and constants for the order book top levels block.
// ----------------------------------------------------------------------------
package obtl_pkg;

  localparam int LEVELS  = 32;
  localparam int PRICE_W = 20;
  localparam int QTY_W   = 16;
  localparam int VOL_W   = 32;
  localparam int DEPTH_W = 6;
  localparam int CNT_W   = $clog2(LEVELS + 1);
  localparam int IDX_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MIN = DEPTH_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(32);

  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_PUBLISH = 1'b1;
  localparam logic SIDE_BUY     = 1'b0;
  localparam logic SIDE_SELL    = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } in_t;

  typedef struct packed {
    logic               out_side;
    logic [PRICE_W-1:0] level_price;
    logic [VOL_W-1:0]   level_volume;
    logic               book_empty;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               vld;
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
  } level_t;

  typedef struct packed {
    logic               add;
    logic               clr;
    logic               asc;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cmd_t;

  typedef struct packed {
    logic eq;
    logic bef;
  } cell_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELL,
    ST_BUY,
    ST_EMPTY
  } state_t;

endpackage

/* rtl/core/obtl_cell.sv */
// ----------------------------------------------------------------------------
// obtl_cell
// One price level of a sorted side: merges, takes its left neighbor or the
// new order, or holds.
// ----------------------------------------------------------------------------
module obtl_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  obtl_pkg::cmd_t    cmd,
  input  logic              hit,
  input  obtl_pkg::level_t  left,
  input  logic              left_bef,
  output obtl_pkg::level_t  lvl,
  output obtl_pkg::cell_st_t st
);
  import obtl_pkg::*;

  level_t             lvl_r;
  level_t             lvl_nxt;
  logic [VOL_W:0]     sum;

  assign st.eq  = lvl_r.vld && (lvl_r.price == cmd.price);
  assign st.bef = !lvl_r.vld ||
                  (cmd.asc ? (cmd.price < lvl_r.price) : (cmd.price > lvl_r.price));
  assign lvl    = lvl_r;

  always_comb begin
    sum     = {1'b0, lvl_r.volume} + {{(VOL_W + 1 - QTY_W){1'b0}}, cmd.qty};
    lvl_nxt = lvl_r;
    if (cmd.add) begin
      if (hit) begin
        if (st.eq) begin
          lvl_nxt.volume = sum[VOL_W] ? {VOL_W{1'b1}} : sum[VOL_W-1:0];
        end
      end else if (left_bef) begin
        lvl_nxt = left;
      end else if (st.bef) begin
        lvl_nxt.vld    = 1'b1;
        lvl_nxt.price  = cmd.price;
        lvl_nxt.volume = {{(VOL_W - QTY_W){1'b0}}, cmd.qty};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r.vld <= 1'b0;
    end else if (cmd.clr) begin
      lvl_r.vld <= 1'b0;
    end else begin
      lvl_r.vld <= lvl_nxt.vld;
    end
    lvl_r.price  <= lvl_nxt.price;
    lvl_r.volume <= lvl_nxt.volume;
  end

endmodule

/* rtl/core/obtl_side.sv */
// ----------------------------------------------------------------------------
// obtl_side
// Chain of level cells for one side of the book, with its level count and
// read port for publishing.
// ----------------------------------------------------------------------------
module obtl_side (
  input  logic                         clk,
  input  logic                         rst_n,
  input  obtl_pkg::cmd_t               cmd,
  input  logic [obtl_pkg::IDX_W-1:0]   rd_idx,
  output obtl_pkg::level_t             rd_lvl,
  output logic [obtl_pkg::CNT_W-1:0]   cnt
);
  import obtl_pkg::*;

  level_t             lvl [LEVELS];
  cell_st_t           st  [LEVELS];
  logic               hit;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      hit = hit | st[i].eq;
    end
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    if (g == 0) begin : g_head
      obtl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .hit      (hit),
        .left     ('0),
        .left_bef (1'b0),
        .lvl      (lvl[g]),
        .st       (st[g])
      );
    end else begin : g_body
      obtl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .hit      (hit),
        .left     (lvl[g-1]),
        .left_bef (st[g-1].bef),
        .lvl      (lvl[g]),
        .st       (st[g])
      );
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr) begin
      cnt_nxt = '0;
    end else if (cmd.add && !hit && (cnt_r != CNT_W'(LEVELS))) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt    = cnt_r;
  assign rd_lvl = lvl[rd_idx];

endmodule

/* rtl/core/order_book_top_levels.sv */
// ----------------------------------------------------------------------------
// order_book_top_levels
// Per-side price level aggregation keeping the best levels, with a publish
// run that emits the shown depth and clears the book.
// ----------------------------------------------------------------------------
// The block takes one add per cycle while it is idle: every level cell of
// a side compares, merges or shifts in the same cycle. A publish beat
// starts a run that sends one result per cycle while out_ready is high
// (the depth shown on each side, or one empty result), and the block takes
// no new input beat until the last result is in the output register. The
// book is cleared as the last result is loaded.
module order_book_top_levels (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  obtl_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output obtl_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [obtl_pkg::DEPTH_W-1:0]  cfg_wdata
);
  import obtl_pkg::*;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DEPTH_W-1:0]   nb_r, nb_nxt;
  logic [DEPTH_W-1:0]   depth_r;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  cmd_t                 sell_cmd, buy_cmd;
  level_t               sell_lvl, buy_lvl;
  logic [CNT_W-1:0]     sell_cnt, buy_cnt;
  logic [DEPTH_W-1:0]   depth_eff, ns, nb;
  logic                 in_acc, slot_free, load, clr;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    depth_eff = depth_r;
    if (depth_r == '0) begin
      depth_eff = DEPTH_MIN;
    end else if (depth_r > DEPTH_MAX) begin
      depth_eff = DEPTH_MAX;
    end
    ns = (DEPTH_W'(sell_cnt) < depth_eff) ? DEPTH_W'(sell_cnt) : depth_eff;
    nb = (DEPTH_W'(buy_cnt) < depth_eff) ? DEPTH_W'(buy_cnt) : depth_eff;
  end

  always_comb begin
    sell_cmd.add   = in_acc && (in_data.kind == KIND_ADD) && (in_data.side == SIDE_SELL);
    sell_cmd.clr   = clr;
    sell_cmd.asc   = 1'b1;
    sell_cmd.price = in_data.price;
    sell_cmd.qty   = in_data.quantity;
    buy_cmd        = sell_cmd;
    buy_cmd.add    = in_acc && (in_data.kind == KIND_ADD) && (in_data.side == SIDE_BUY);
    buy_cmd.asc    = 1'b0;
  end

  obtl_side u_sell (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (sell_cmd),
    .rd_idx (idx_r),
    .rd_lvl (sell_lvl),
    .cnt    (sell_cnt)
  );

  obtl_side u_buy (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (buy_cmd),
    .rd_idx (idx_r),
    .rd_lvl (buy_lvl),
    .cnt    (buy_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      depth_r     <= DEPTH_MIN;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        depth_r <= cfg_wdata;
      end
    end
    idx_r      <= idx_nxt;
    nb_r       <= nb_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    nb_nxt        = nb_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load          = 1'b0;
    clr           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.kind == KIND_PUBLISH)) begin
          nb_nxt = nb;
          if (ns != '0) begin
            state_nxt = ST_SELL;
            idx_nxt   = IDX_W'(ns - DEPTH_W'(1));
          end else if (nb != '0) begin
            state_nxt = ST_BUY;
            idx_nxt   = '0;
          end else begin
            state_nxt = ST_EMPTY;
          end
        end
      end
      ST_SELL: begin
        if (slot_free) begin
          load                      = 1'b1;
          out_data_nxt.out_side     = SIDE_SELL;
          out_data_nxt.level_price  = sell_lvl.price;
          out_data_nxt.level_volume = sell_lvl.volume;
          out_data_nxt.book_empty   = 1'b0;
          out_data_nxt.last         = (idx_r == '0) && (nb_r == '0);
          if (idx_r == '0) begin
            if (nb_r == '0) begin
              state_nxt = ST_IDLE;
              clr       = 1'b1;
            end else begin
              state_nxt = ST_BUY;
            end
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      ST_BUY: begin
        if (slot_free) begin
          load                      = 1'b1;
          out_data_nxt.out_side     = SIDE_BUY;
          out_data_nxt.level_price  = buy_lvl.price;
          out_data_nxt.level_volume = buy_lvl.volume;
          out_data_nxt.book_empty   = 1'b0;
          out_data_nxt.last         = (DEPTH_W'(idx_r) == nb_r - DEPTH_W'(1));
          if (out_data_nxt.last) begin
            state_nxt = ST_IDLE;
            clr       = 1'b1;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          load                      = 1'b1;
          out_data_nxt.out_side     = SIDE_BUY;
          out_data_nxt.level_price  = '0;
          out_data_nxt.level_volume = '0;
          out_data_nxt.book_empty   = 1'b1;
          out_data_nxt.last         = 1'b1;
          state_nxt                 = ST_IDLE;
          clr                       = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.book_empty) |-> (out_data.last && (out_data.level_volume == '0)))
    else $error("empty result not a lone last beat");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_data_nxt.last) |=> (state_r == ST_IDLE))
    else $error("run continues after last beat");

  a_buy_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUY) |-> (DEPTH_W'(idx_r) < nb_r))
    else $error("buy read index beyond shown depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> ((sell_cnt == '0) && (buy_cnt == '0)))
    else $error("book not cleared after publish");

endmodule

/* tb/sv/obtl_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obtl_checker
// Watches the order and level channels of the order book block, keeps its own
// per-side book of best price levels and checks every level beat it sends.
// ----------------------------------------------------------------------------
// Orders are folded into a sorted table per side as they are accepted. A
// publish beat turns the table into the list of levels due, sell run first,
// then buy, and clears the book. Level beats are compared field by field with
// the oldest level due. The shown depth follows the configuration port.
// ----------------------------------------------------------------------------
module obtl_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  obtl_pkg::in_t                 in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  obtl_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [obtl_pkg::DEPTH_W-1:0]  cfg_wdata,
  output int                            pending,
  output int                            mismatches,
  output int                            beats_in,
  output int                            levels_checked
);
  import obtl_pkg::*;

  logic [PRICE_W-1:0] book_px  [0:1][0:LEVELS-1];
  logic [VOL_W-1:0]   book_vol [0:1][0:LEVELS-1];
  int                 book_cnt [0:1];
  logic [DEPTH_W-1:0] depth_reg;
  out_t               levels_due[$];

  function automatic void book_add_order(logic s, logic [PRICE_W-1:0] p,
                                         logic [QTY_W-1:0] q);
    int          n;
    int          pos;
    int          i;
    logic        hit;
    logic        placed;
    logic [VOL_W:0] sum;
    n = book_cnt[s];
    pos = n;
    hit = 1'b0;
    placed = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!hit && !placed) begin
        if (book_px[s][i] == p) begin
          hit = 1'b1;
          sum = {1'b0, book_vol[s][i]} + {{(VOL_W + 1 - QTY_W){1'b0}}, q};
          book_vol[s][i] = sum[VOL_W] ? {VOL_W{1'b1}} : sum[VOL_W-1:0];
        end else if ((s == SIDE_SELL) ? (p < book_px[s][i]) : (p > book_px[s][i])) begin
          pos = i;
          placed = 1'b1;
        end
      end
    end
    if (!hit && pos < LEVELS) begin
      if (n < LEVELS) begin
        book_cnt[s] = n + 1;
      end else begin
        n = LEVELS - 1;
      end
      for (i = n; i > pos; i--) begin
        book_px[s][i]  = book_px[s][i-1];
        book_vol[s][i] = book_vol[s][i-1];
      end
      book_px[s][pos]  = p;
      book_vol[s][pos] = {{(VOL_W - QTY_W){1'b0}}, q};
    end
  endfunction

  function automatic void book_publish();
    int   d;
    int   ns;
    int   nb;
    int   k;
    int   j;
    out_t lv;
    d = int'(depth_reg);
    if (d < int'(DEPTH_MIN)) d = int'(DEPTH_MIN);
    if (d > int'(DEPTH_MAX)) d = int'(DEPTH_MAX);
    ns = (book_cnt[SIDE_SELL] < d) ? book_cnt[SIDE_SELL] : d;
    nb = (book_cnt[SIDE_BUY] < d) ? book_cnt[SIDE_BUY] : d;
    if (ns == 0 && nb == 0) begin
      lv = '0;
      lv.book_empty = 1'b1;
      lv.last = 1'b1;
      levels_due = {levels_due, lv};
    end else begin
      k = ns + nb;
      for (j = 0; j < k; j++) begin
        lv = '0;
        if (j < ns) begin
          // sell table is lowest first, shown highest first
          lv.out_side     = SIDE_SELL;
          lv.level_price  = book_px[SIDE_SELL][ns-1-j];
          lv.level_volume = book_vol[SIDE_SELL][ns-1-j];
        end else begin
          lv.out_side     = SIDE_BUY;
          lv.level_price  = book_px[SIDE_BUY][j-ns];
          lv.level_volume = book_vol[SIDE_BUY][j-ns];
        end
        lv.last = (j == k - 1);
        levels_due = {levels_due, lv};
      end
    end
    book_cnt[SIDE_BUY] = 0;
    book_cnt[SIDE_SELL] = 0;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      book_cnt[SIDE_BUY] = 0;
      book_cnt[SIDE_SELL] = 0;
      depth_reg = DEPTH_MIN;
      levels_due.delete();
      pending <= 0;
      mismatches <= 0;
      beats_in <= 0;
      levels_checked <= 0;
    end else begin
      if (cfg_we) begin
        depth_reg = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        levels_checked <= levels_checked + 1;
        if (levels_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: level beat with none due: side %0d price %0d volume %0d empty %0d last %0d",
                     $time, out_data.out_side, out_data.level_price, out_data.level_volume,
                     out_data.book_empty, out_data.last);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = levels_due.pop_front();
          if (out_data.out_side !== want.out_side ||
              out_data.level_price !== want.level_price ||
              out_data.level_volume !== want.level_volume ||
              out_data.book_empty !== want.book_empty ||
              out_data.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: level mismatch, expected side %0d price %0d volume %0d empty %0d last %0d",
                       $time, want.out_side, want.level_price, want.level_volume,
                       want.book_empty, want.last);
              $display("%0t:                   got side %0d price %0d volume %0d empty %0d last %0d",
                       $time, out_data.out_side, out_data.level_price, out_data.level_volume,
                       out_data.book_empty, out_data.last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        beats_in <= beats_in + 1;
        if (in_data.kind == KIND_PUBLISH) begin
          book_publish();
        end else begin
          book_add_order(in_data.side, in_data.price, in_data.quantity);
        end
      end
      pending <= levels_due.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the order book top levels block.
// ----------------------------------------------------------------------------
// A short directed run covers empty and one-sided books, zero quantities,
// price and quantity extremes and ignored publish fields. Random books follow
// over several shown depths, including out-of-range ones, with some full
// sides and noise beats. The sender works in bursts with gaps, the receiver
// stalls on its own pattern, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb;
  import obtl_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE     = 4;
  localparam int DRAIN      = 16;
  localparam int RX_OPEN    = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_BURSTY  = 2;

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
  localparam logic [QTY_W-1:0]   QTY_MAX   = {QTY_W{1'b1}};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               cfg_we = 1'b0;
  logic [DEPTH_W-1:0] cfg_wdata = '0;

  int pending;
  int mismatches;
  int beats_in;
  int levels_checked;
  int rx_mode = RX_BURSTY;
  int rx_cnt = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int depth_writes = 0;
  bit quiet = 1'b0;

  order_book_top_levels dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  obtl_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .pending        (pending),
    .mismatches     (mismatches),
    .beats_in       (beats_in),
    .levels_checked (levels_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cnt <= 0;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          out_ready <= 1'b1;
        end
        RX_COIN: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (rx_cnt == 0) begin
            out_ready <= !out_ready;
            rx_cnt <= out_ready ? $urandom_range(1, 8) : $urandom_range(1, 10);
          end else begin
            rx_cnt <= rx_cnt - 1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d levels still due", IDLE_LIMIT, pending);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic in_t add_beat(logic s, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
    in_t b;
    b.kind = KIND_ADD;
    b.side = s;
    b.price = p;
    b.quantity = q;
    return b;
  endfunction

  // side, price and quantity are don't-care on publish, so fill them with noise
  function automatic in_t publish_beat();
    in_t b;
    b.kind = KIND_PUBLISH;
    b.side = 1'($urandom_range(0, 1));
    b.price = PRICE_W'($urandom);
    b.quantity = QTY_W'($urandom);
    return b;
  endfunction

  function automatic logic [QTY_W-1:0] rand_qty();
    logic [QTY_W-1:0] q;
    case ($urandom_range(0, 5))
      0: q = '0;
      1: q = QTY_MAX;
      default: q = QTY_W'($urandom);
    endcase
    return q;
  endfunction

  task automatic send_beat(input in_t b);
    int gap;
    if (burst_left == 0) begin
      gap = quiet ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left = burst_left - 1;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_depth(input logic [DEPTH_W-1:0] v);
    wait_drained();
    // a trailing add may still be in flight
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    depth_writes = depth_writes + 1;
    quiet = ($urandom_range(0, 2) == 0);
    rx_mode <= $urandom_range(RX_OPEN, RX_BURSTY);
  endtask

  task automatic run_books(input int target);
    int               sent;
    int               n;
    int               i;
    int               r;
    int               span;
    logic             lean;
    logic             s;
    logic [PRICE_W-1:0] base;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        // one book: a run of adds in a price window, then publish
        n = (r == 0) ? $urandom_range(36, 48) : $urandom_range(0, 10);
        span = (r == 0) ? 60 : ($urandom_range(0, 1) ? 8 : 4000);
        case ($urandom_range(0, 3))
          0: base = '0;
          1: base = PRICE_MAX - PRICE_W'(span);
          default: base = PRICE_W'($urandom);
        endcase
        lean = 1'($urandom_range(0, 1));
        for (i = 0; i < n; i++) begin
          if (r == 0) begin
            s = ($urandom_range(0, 7) == 0) ? !lean : lean;
          end else begin
            s = 1'($urandom_range(0, 1));
          end
          send_beat(add_beat(s, base + PRICE_W'($urandom_range(0, span)), rand_qty()));
        end
        send_beat(publish_beat());
        sent = sent + n + 1;
      end else if (r == 8) begin
        send_beat(add_beat(1'($urandom_range(0, 1)), PRICE_W'($urandom), QTY_W'($urandom)));
        sent = sent + 1;
      end else begin
        send_beat(publish_beat());
        sent = sent + 1;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset depth of one
    send_beat(publish_beat());
    send_beat(add_beat(SIDE_SELL, '0, '0));
    send_beat(add_beat(SIDE_BUY, PRICE_MAX, QTY_MAX));
    send_beat(add_beat(SIDE_BUY, PRICE_MAX, QTY_MAX));
    send_beat(publish_beat());
    send_beat(add_beat(SIDE_SELL, PRICE_W'(100), QTY_W'(5)));
    send_beat(add_beat(SIDE_SELL, PRICE_W'(50), QTY_W'(7)));
    send_beat(publish_beat());
    send_beat(add_beat(SIDE_BUY, PRICE_W'(9), QTY_W'(1)));
    send_beat(publish_beat());

    set_depth(DEPTH_MAX);
    send_beat(add_beat(SIDE_BUY, PRICE_W'(10), QTY_W'(1)));
    send_beat(add_beat(SIDE_BUY, PRICE_W'(30), QTY_W'(2)));
    send_beat(add_beat(SIDE_BUY, PRICE_W'(20), QTY_W'(3)));
    send_beat(add_beat(SIDE_SELL, PRICE_W'(40), QTY_W'(4)));
    send_beat(add_beat(SIDE_SELL, PRICE_W'(60), QTY_W'(5)));
    send_beat(add_beat(SIDE_SELL, PRICE_W'(50), QTY_W'(6)));
    send_beat(add_beat(SIDE_SELL, PRICE_W'(50), QTY_W'(7)));
    send_beat(publish_beat());

    set_depth('0);
    send_beat(add_beat(SIDE_SELL, PRICE_W'(70), QTY_W'(1)));
    send_beat(add_beat(SIDE_SELL, PRICE_W'(60), QTY_W'(2)));
    send_beat(add_beat(SIDE_BUY, PRICE_W'(5), QTY_W'(3)));
    send_beat(add_beat(SIDE_BUY, PRICE_W'(8), QTY_W'(4)));
    send_beat(publish_beat());

    // random books over several depths
    set_depth({DEPTH_W{1'b1}});
    run_books(35);
    set_depth(DEPTH_MAX + DEPTH_W'(1));
    run_books(35);
    set_depth(DEPTH_W'(5));
    run_books(35);
    set_depth(DEPTH_W'($urandom_range(2, 31)));
    run_books(35);
    set_depth(DEPTH_MIN);
    run_books(35);

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d input beats and %0d checked level beats over %0d depth writes",
             beats_in, levels_checked, depth_writes);
    $display("incl. empty and one-sided books, full sides and out-of-range depths");
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/obtl_pkg.sv
rtl/core/obtl_cell.sv
rtl/core/obtl_side.sv
rtl/core/order_book_top_levels.sv
tb/sv/obtl_checker.sv
tb/sv/tb.sv
